// ===== rtl/qs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qs_pkg - shared types and constants of the quaternion slerp block
// Payload structs, fixed-point constants, CORDIC angle table, saturation.
// ----------------------------------------------------------------------------
package qs_pkg;

    localparam int COMP_WIDTH = 16;
    localparam int NUM_WIDTH  = 48;

    localparam logic [15:0]        THR_RESET   = 16'd31130;
    localparam logic [15:0]        ONE_Q15     = 16'd32768;
    localparam logic [17:0]        MAG_CAP     = 18'd131072;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    typedef struct packed {
        logic signed [COMP_WIDTH-1:0] a_x;
        logic signed [COMP_WIDTH-1:0] a_y;
        logic signed [COMP_WIDTH-1:0] a_z;
        logic signed [COMP_WIDTH-1:0] a_w;
        logic signed [COMP_WIDTH-1:0] b_x;
        logic signed [COMP_WIDTH-1:0] b_y;
        logic signed [COMP_WIDTH-1:0] b_z;
        logic signed [COMP_WIDTH-1:0] b_w;
        logic [15:0]                  rate;
    } qs_in_t;

    typedef struct packed {
        logic signed [COMP_WIDTH-1:0] r_x;
        logic signed [COMP_WIDTH-1:0] r_y;
        logic signed [COMP_WIDTH-1:0] r_z;
        logic signed [COMP_WIDTH-1:0] r_w;
        logic                         used_linear;
        logic                         flipped;
    } qs_out_t;

    // Classified item handed from the front end to the back end
    typedef struct packed {
        logic [3:0][COMP_WIDTH-1:0] a;
        logic [3:0][COMP_WIDTH:0]   b;      // already negated for the short arc
        logic [15:0]                t;      // rate clamped to 1.0
        logic [15:0]                d;      // |dot| clamped to 1.0, Q1.15
        logic                       linear;
        logic                       flip;
    } qs_job_t;

    // Sideband carried along the back-end pipeline
    typedef struct packed {
        logic [3:0][COMP_WIDTH-1:0] a;
        logic [3:0][COMP_WIDTH:0]   b;
        logic [15:0]                t;
        logic [15:0]                d;
        logic                       linear;
        logic                       flip;
        logic [3:0][COMP_WIDTH-1:0] r_lin;
    } qs_side_t;

    // CORDIC step angle atan(2^-i) in Q30
    function automatic logic signed [33:0] atan_q30(input int i);
        logic signed [33:0] r;
        case (i)
            0:       r = 34'sd843314857;
            1:       r = 34'sd497837829;
            2:       r = 34'sd263043837;
            3:       r = 34'sd133525159;
            4:       r = 34'sd67021687;
            5:       r = 34'sd33543516;
            6:       r = 34'sd16775851;
            7:       r = 34'sd8388437;
            8:       r = 34'sd4194283;
            9:       r = 34'sd2097149;
            default: r = (i <= 30) ? (34'sd1 <<< (30 - i)) : 34'sd0;
        endcase
        return r;
    endfunction

    // Clip a wide signed value to one component
    function automatic logic [COMP_WIDTH-1:0] sat_comp(input logic signed [NUM_WIDTH-1:0] v);
        logic [COMP_WIDTH-1:0] r;
        if (v > 48'sd32767) begin
            r = 16'h7fff;
        end else if (v < -48'sd32768) begin
            r = 16'h8000;
        end else begin
            r = v[COMP_WIDTH-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/qs_cordic.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qs_cordic - pipelined CORDIC, one iteration per stage
// Vectoring mode drives y to zero and accumulates the angle in z; rotation
// mode drives z to zero. Advances only when en is high.
// ----------------------------------------------------------------------------
module qs_cordic #(
    parameter int STEPS  = 16,
    parameter bit ROTATE = 1'b0
) (
    input  logic               aclk,
    input  logic               en,
    input  logic signed [33:0] x_in,
    input  logic signed [33:0] y_in,
    input  logic signed [33:0] z_in,
    output logic signed [33:0] y_out,
    output logic signed [33:0] z_out
);
    import qs_pkg::*;

    logic signed [33:0] x_reg [STEPS];
    logic signed [33:0] y_reg [STEPS];
    logic signed [33:0] z_reg [STEPS];
    logic signed [33:0] xi [STEPS];
    logic signed [33:0] yi [STEPS];
    logic signed [33:0] zi [STEPS];

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        logic signed [33:0] x_next, y_next, z_next;

        if (i == 0) begin : g_first
            assign xi[i] = x_in;
            assign yi[i] = y_in;
            assign zi[i] = z_in;
        end else begin : g_rest
            assign xi[i] = x_reg[i-1];
            assign yi[i] = y_reg[i-1];
            assign zi[i] = z_reg[i-1];
        end

        // pick the direction from y (vectoring) or z (rotation)
        always_comb begin
            logic up;
            up = ROTATE ? !zi[i][33] : yi[i][33];
            if (up) begin
                x_next = xi[i] - (yi[i] >>> i);
                y_next = yi[i] + (xi[i] >>> i);
                z_next = zi[i] - atan_q30(i);
            end else begin
                x_next = xi[i] + (yi[i] >>> i);
                y_next = yi[i] - (xi[i] >>> i);
                z_next = zi[i] + atan_q30(i);
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[i] <= x_next;
                y_reg[i] <= y_next;
                z_reg[i] <= z_next;
            end
        end
    end

    assign y_out = y_reg[STEPS-1];
    assign z_out = z_reg[STEPS-1];

endmodule
`default_nettype wire

// ===== rtl/qs_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qs_front - input stage: dot product and path selection
// Two stages: component products, then dot sum, short-arc flip and
// linear/spherical decision. Stalls only when the queue is full.
// ----------------------------------------------------------------------------
module qs_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  qs_pkg::qs_in_t  s_data,
    input  logic [15:0]     thr,
    input  logic            q_full,
    output logic            push,
    output qs_pkg::qs_job_t push_data
);
    import qs_pkg::*;

    logic f_en;
    logic f1_valid_reg, f2_valid_reg;
    logic signed [31:0] p_reg [4];
    logic signed [COMP_WIDTH-1:0] a_reg [4];
    logic signed [COMP_WIDTH-1:0] b_reg [4];
    logic [15:0] t_reg;
    logic signed [COMP_WIDTH-1:0] in_a [4];
    logic signed [COMP_WIDTH-1:0] in_b [4];
    qs_job_t job_next, job_reg;

    assign f_en    = !q_full;
    assign s_ready = f_en;
    assign push    = f2_valid_reg && f_en;
    assign push_data = job_reg;

    assign in_a[0] = s_data.a_x;
    assign in_a[1] = s_data.a_y;
    assign in_a[2] = s_data.a_z;
    assign in_a[3] = s_data.a_w;
    assign in_b[0] = s_data.b_x;
    assign in_b[1] = s_data.b_y;
    assign in_b[2] = s_data.b_z;
    assign in_b[3] = s_data.b_w;

    // advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
        end else if (f_en) begin
            f1_valid_reg <= s_valid;
            f2_valid_reg <= f1_valid_reg;
        end
    end

    // form products and clamp the rate
    always_ff @(posedge aclk) begin
        if (f_en) begin
            for (int i = 0; i < 4; i++) begin
                p_reg[i] <= in_a[i] * in_b[i];
                a_reg[i] <= in_a[i];
                b_reg[i] <= in_b[i];
            end
            t_reg <= (s_data.rate > ONE_Q15) ? ONE_Q15 : s_data.rate;
            job_reg <= job_next;
        end
    end

    // sum the dot, take its magnitude and pick the path
    always_comb begin
        logic signed [33:0] dot;
        logic [33:0]        abs_dot;
        logic [19:0]        m20;
        logic [17:0]        mag;
        logic signed [COMP_WIDTH:0] bx;
        dot = 34'(p_reg[0]) + 34'(p_reg[1]) + 34'(p_reg[2]) + 34'(p_reg[3]);
        abs_dot = dot[33] ? 34'(-dot) : 34'(dot);
        m20 = abs_dot[32:13];
        mag = (m20 > 20'(MAG_CAP)) ? MAG_CAP : m20[17:0];
        job_next.flip   = dot[33];
        job_next.t      = t_reg;
        job_next.d      = (mag >= 18'(ONE_Q15)) ? ONE_Q15 : mag[15:0];
        job_next.linear = (mag >= {2'b00, thr}) || (mag >= 18'(ONE_Q15));
        for (int i = 0; i < 4; i++) begin
            bx = 17'(b_reg[i]);
            job_next.a[i] = a_reg[i];
            job_next.b[i] = dot[33] ? 17'(-bx) : bx;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/qs_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qs_queue - four-entry queue between front and back end
// Lets the front keep accepting while the back end is stalled.
// ----------------------------------------------------------------------------
module qs_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  qs_pkg::qs_job_t push_data,
    output logic            full,
    input  logic            pop,
    output logic            q_valid,
    output qs_pkg::qs_job_t q_data
);
    import qs_pkg::*;

    localparam int DEPTH = 4;

    qs_job_t mem_reg [DEPTH];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] count_reg;
    logic       do_pop;

    assign full    = (count_reg == 3'(DEPTH));
    assign q_valid = (count_reg != 3'd0);
    assign q_data  = mem_reg[rd_ptr_reg];
    assign do_pop  = pop && q_valid;

    // move pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_reg + 3'(push) - 3'(do_pop);
        end
    end

    // store entries
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/qs_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qs_back - back-end pipeline: sqrt, CORDIC angle and sines, divide
// All stages advance together whenever the output register can take a beat.
// The linear blend is formed up front and carried along as sideband.
// ----------------------------------------------------------------------------
module qs_back #(
    parameter int STEPS = 16
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    input  qs_pkg::qs_job_t in_data,
    output logic            pop,
    output logic            m_valid,
    input  logic            m_ready,
    output qs_pkg::qs_out_t m_data
);
    import qs_pkg::*;

    // layer at which each value sits, counted in register stages
    localparam int L_S   = 32;
    localparam int L_TH  = L_S + STEPS;
    localparam int L_ANG = L_TH + 1;
    localparam int L_SIN = L_ANG + STEPS;
    localparam int L_PR  = L_SIN + 1;
    localparam int L_SUM = L_PR + 1;
    localparam int L_ABS = L_SUM + 1;
    localparam int L_OVF = L_ABS + 1;
    localparam int L_END = L_OVF + 16;
    localparam int NW    = NUM_WIDTH;

    logic en;
    logic [L_END:1] vld_reg;
    qs_side_t side_reg [1:L_END];
    logic [30:0] s_reg [L_S:L_END-1];
    logic [30:0] sq_root;
    qs_side_t side0;
    logic [61:0] v0_reg;
    logic m_valid_reg;
    qs_out_t m_data_reg, out_next;

    assign en      = !m_valid_reg || m_ready;
    assign pop     = en;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // shift valid bits and sideband
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg     <= {vld_reg[L_END-1:1], in_valid};
            m_valid_reg <= vld_reg[L_END];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[1] <= side0;
            for (int k = 2; k <= L_END; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
            s_reg[L_S] <= sq_root;
            for (int k = L_S + 1; k < L_END; k++) begin
                s_reg[k] <= s_reg[k-1];
            end
            m_data_reg <= out_next;
        end
    end

    // form the linear blend and the sqrt operand
    logic [31:0] dd;
    assign dd = in_data.d * in_data.d;

    always_comb begin
        logic signed [17:0] diff;
        logic signed [34:0] lprod;
        logic signed [36:0] lacc;
        logic signed [36:0] lq;
        side0.a      = in_data.a;
        side0.b      = in_data.b;
        side0.t      = in_data.t;
        side0.d      = in_data.d;
        side0.linear = in_data.linear;
        side0.flip   = in_data.flip;
        for (int i = 0; i < 4; i++) begin
            diff  = 18'($signed(in_data.b[i])) - 18'($signed(in_data.a[i]));
            lprod = $signed({1'b0, in_data.t}) * diff;
            lacc  = (37'($signed(in_data.a[i])) <<< 15) + 37'(lprod) + 37'sd16384;
            lq    = lacc >>> 15;
            side0.r_lin[i] = sat_comp(NW'(lq));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            v0_reg <= {(32'd1073741824 - dd), 30'd0};
        end
    end

    // square root, one result bit per stage
    logic [61:0] sq_v_reg [30];
    logic [61:0] sq_r_reg [30];
    logic [61:0] sq_vi [31];
    logic [61:0] sq_ri [31];

    for (genvar j = 0; j < 31; j++) begin : g_sqrt
        logic [61:0] v_next, r_next;

        if (j == 0) begin : g_first
            assign sq_vi[j] = v0_reg;
            assign sq_ri[j] = '0;
        end else begin : g_rest
            assign sq_vi[j] = sq_v_reg[j-1];
            assign sq_ri[j] = sq_r_reg[j-1];
        end

        always_comb begin
            logic [61:0] one;
            one = 62'd1 << (60 - 2 * j);
            if (sq_vi[j] >= sq_ri[j] + one) begin
                v_next = sq_vi[j] - (sq_ri[j] + one);
                r_next = (sq_ri[j] >> 1) + one;
            end else begin
                v_next = sq_vi[j];
                r_next = sq_ri[j] >> 1;
            end
        end

        if (j < 30) begin : g_mid
            always_ff @(posedge aclk) begin
                if (en) begin
                    sq_v_reg[j] <= v_next;
                    sq_r_reg[j] <= r_next;
                end
            end
        end else begin : g_last
            assign sq_root = r_next[30:0];
        end
    end

    // theta = atan2(sin, cos)
    logic signed [33:0] theta;

    qs_cordic #(.STEPS(STEPS), .ROTATE(1'b0)) u_atan (
        .aclk  (aclk),
        .en    (en),
        .x_in  ({3'b000, side_reg[L_S].d, 15'd0}),
        .y_in  ({3'b000, s_reg[L_S]}),
        .z_in  (34'sd0),
        .y_out (),
        .z_out (theta)
    );

    // scale the angle by t and by 1 - t
    logic signed [33:0] ang2_reg, ang3_reg;
    logic signed [50:0] m2;
    logic signed [51:0] m3;
    logic [16:0] tc;

    assign tc = 17'(ONE_Q15) - {1'b0, side_reg[L_TH].t};
    assign m2 = theta * $signed({1'b0, side_reg[L_TH].t});
    assign m3 = theta * $signed({1'b0, tc});

    always_ff @(posedge aclk) begin
        if (en) begin
            ang2_reg <= 34'(m2 >>> 15);
            ang3_reg <= 34'(m3 >>> 15);
        end
    end

    // sines of both partial angles
    logic signed [33:0] s2, s3;

    qs_cordic #(.STEPS(STEPS), .ROTATE(1'b1)) u_sin_t (
        .aclk  (aclk),
        .en    (en),
        .x_in  (CORDIC_GAIN),
        .y_in  (34'sd0),
        .z_in  (ang2_reg),
        .y_out (s2),
        .z_out ()
    );

    qs_cordic #(.STEPS(STEPS), .ROTATE(1'b1)) u_sin_u (
        .aclk  (aclk),
        .en    (en),
        .x_in  (CORDIC_GAIN),
        .y_in  (34'sd0),
        .z_in  (ang3_reg),
        .y_out (s3),
        .z_out ()
    );

    // weight the components, sum, and take the rounded magnitude
    logic signed [NW-1:0] pa_reg [4];
    logic signed [NW-1:0] pb_reg [4];
    logic signed [NW-1:0] num_reg [4];
    logic [NW-1:0]        n_reg [4];
    logic [3:0]           neg_reg;
    logic signed [49:0]   pa_w [4];
    logic signed [50:0]   pb_w [4];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            pa_w[i] = $signed(side_reg[L_SIN].a[i]) * s3;
            pb_w[i] = $signed(side_reg[L_SIN].b[i]) * s2;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                pa_reg[i]  <= pa_w[i][NW-1:0];
                pb_reg[i]  <= pb_w[i][NW-1:0];
                num_reg[i] <= pa_reg[i] + pb_reg[i];
                neg_reg[i] <= num_reg[i][NW-1];
                n_reg[i]   <= (num_reg[i][NW-1] ? NW'(-num_reg[i]) : NW'(num_reg[i]))
                              + NW'(s_reg[L_SUM] >> 1);
            end
        end
    end

    // detect quotients past the clamp, then restoring divide
    logic [NW-1:0] dv_r_reg [17][4];
    logic [15:0]   dv_q_reg [17][4];
    logic [3:0]    dv_neg_reg [17];
    logic [3:0]    dv_ovf_reg [17];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                dv_r_reg[0][i]   <= n_reg[i];
                dv_q_reg[0][i]   <= 16'd0;
                dv_ovf_reg[0][i] <= (n_reg[i] >= (NW'(s_reg[L_ABS]) << 16));
            end
            dv_neg_reg[0] <= neg_reg;
        end
    end

    for (genvar k = 0; k < 16; k++) begin : g_div
        always_ff @(posedge aclk) begin
            logic [NW-1:0] ds;
            if (en) begin
                ds = NW'(s_reg[L_OVF + k]) << (15 - k);
                for (int i = 0; i < 4; i++) begin
                    if (dv_r_reg[k][i] >= ds) begin
                        dv_r_reg[k+1][i] <= dv_r_reg[k][i] - ds;
                        dv_q_reg[k+1][i] <= {dv_q_reg[k][i][14:0], 1'b1};
                    end else begin
                        dv_r_reg[k+1][i] <= dv_r_reg[k][i];
                        dv_q_reg[k+1][i] <= {dv_q_reg[k][i][14:0], 1'b0};
                    end
                end
                dv_neg_reg[k+1] <= dv_neg_reg[k];
                dv_ovf_reg[k+1] <= dv_ovf_reg[k];
            end
        end
    end

    // pick the path, clamp and sign the spherical quotient
    always_comb begin
        logic [16:0] qm;
        logic signed [17:0] sph;
        logic [3:0][COMP_WIDTH-1:0] r;
        for (int i = 0; i < 4; i++) begin
            if (dv_ovf_reg[16][i] || dv_q_reg[16][i] > ONE_Q15) begin
                qm = 17'(ONE_Q15);
            end else begin
                qm = {1'b0, dv_q_reg[16][i]};
            end
            sph = dv_neg_reg[16][i] ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
            r[i] = side_reg[L_END].linear ? side_reg[L_END].r_lin[i] : sat_comp(NW'(sph));
        end
        out_next.r_x         = r[0];
        out_next.r_y         = r[1];
        out_next.r_z         = r[2];
        out_next.r_w         = r[3];
        out_next.used_linear = side_reg[L_END].linear;
        out_next.flipped     = side_reg[L_END].flip;
    end

endmodule
`default_nettype wire

// ===== rtl/quaternion_slerp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_slerp - spherical quaternion blend with linear fallback
// Input beat: quaternions a, b (Q1.14) and rate t (Q1.15) on s_valid/s_ready.
// Result beat: blended quaternion plus used_linear and flipped on
// m_valid/m_ready, one result per input, in order.
// cfg_valid/cfg_ready writes lerp_threshold (Q1.15); cfg_ready is always high.
// Write it only while no beats are in flight.
// Throughput: one beat per cycle, sustained while m_ready stays high.
// Input to result passes two front stages, the queue, the 31-stage square
// root, the two CORDIC chains and the 17-stage divider.
// When m_ready is low with a result waiting, the back-end pipeline holds; the
// front keeps accepting until its four-entry queue fills, then s_ready drops.
// Reset (aresetn low, synchronous) empties every stage and the queue and
// restores the threshold to 0.95. No clearing pass is needed.
// ----------------------------------------------------------------------------
module quaternion_slerp #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  qs_pkg::qs_in_t  s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output qs_pkg::qs_out_t m_data,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [15:0]     cfg_data
);
    import qs_pkg::*;

    logic [15:0] thr_reg;
    logic        q_full, push, q_valid, pop;
    qs_job_t     push_data, q_data;

    assign cfg_ready = 1'b1;

    // hold the threshold register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THR_RESET;
        end else if (cfg_valid) begin
            thr_reg <= cfg_data;
        end
    end

    qs_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .thr       (thr_reg),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    qs_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_data    (q_data)
    );

    qs_back #(.STEPS(CORDIC_STEPS)) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (q_valid),
        .in_data  (q_data),
        .pop      (pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule
`default_nettype wire

// ===== rtl/qs_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qs_checker - port-level checks for quaternion_slerp
// Output beat holding under stall and reset behavior of both channels.
// ----------------------------------------------------------------------------
module qs_checker (
    input logic            aclk,
    input logic            aresetn,
    input logic            s_ready,
    input logic            m_valid,
    input logic            m_ready,
    input qs_pkg::qs_out_t m_data
);
    import qs_pkg::*;

    // stalled result beat stays up
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result beat dropped while stalled");

    // stalled result beat keeps its payload
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_data))
        else $error("result payload changed while stalled");

    // queue is empty after reset, so input is open
    a_reset_ready: assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("input not ready after reset");

    // reset leaves no result beat valid
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid ##1 !m_valid)
        else $error("result beat right after reset");

endmodule

bind quaternion_slerp qs_checker u_qs_checker (.*);
`default_nettype wire

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb - self-checking testbench for quaternion_slerp
// Drives quaternion pairs and blend rates through the valid/ready input,
// predicts each result in SystemVerilog fixed point, and compares every
// result beat field by field, in order. The test steps through several
// lerp_threshold settings, and both sides idle in random bursts.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import qs_pkg::*;

    localparam longint ONE_Q30    = 64'sd1073741824;
    localparam longint GAIN_Q30   = 64'sd652032874;
    localparam longint STEPS      = 16;
    localparam int     DRAIN_WAIT = 200;

    localparam longint ATAN_TABLE [10] = '{
        843314857, 497837829, 263043837, 133525159, 67021687,
        33543516, 16775851, 8388437, 4194283, 2097149
    };

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    qs_in_t      s_data;
    logic        m_valid;
    logic        m_ready;
    qs_out_t     m_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    qs_out_t     expected_blends[$];
    longint      lerp_thr;
    int          errors;
    bit          idle_on;

    quaternion_slerp u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // 100 MHz clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // ---------------- fixed-point predictor ----------------

    function automatic longint atan_step(longint i);
        if (i < 10) begin
            return ATAN_TABLE[i];
        end
        return 64'sd1 <<< (30 - i);
    endfunction

    function automatic longint unsigned isqrt64(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Vectoring mode: angle of (x, y) in Q30 radians
    function automatic longint angle_of(longint y, longint x);
        longint z;
        longint nx;
        z = 0;
        for (longint i = 0; i < STEPS; i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + atan_step(i);
            end else begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - atan_step(i);
            end
            x = nx;
        end
        return z;
    endfunction

    // Rotation mode: sine of a Q30 angle
    function automatic longint sine_of(longint z);
        longint x;
        longint y;
        longint nx;
        x = GAIN_Q30;
        y = 0;
        for (longint i = 0; i < STEPS; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - atan_step(i);
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + atan_step(i);
            end
            x = nx;
        end
        return y;
    endfunction

    // Round half away from zero, capped at 2^15 in magnitude
    function automatic longint div_nearest(longint num, longint den);
        longint unsigned mag;
        longint unsigned q;
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        if (q > 32768) q = 32768;
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic [15:0] clip16(longint v);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    function automatic qs_out_t predict_blend(qs_in_t x);
        longint a [4];
        longint b [4];
        longint r [4];
        longint dot;
        longint mag;
        longint t;
        longint d;
        longint s;
        longint theta;
        longint s2;
        longint s3;
        bit     flip;
        bit     lin;
        qs_out_t o;
        a = '{x.a_x, x.a_y, x.a_z, x.a_w};
        b = '{x.b_x, x.b_y, x.b_z, x.b_w};
        t = x.rate;
        if (t > 32768) t = 32768;
        dot = 0;
        for (int i = 0; i < 4; i++) dot += a[i] * b[i];
        // take the short arc on a negative dot
        flip = dot < 0;
        mag = (flip ? -dot : dot) >>> 13;
        if (mag > 131072) mag = 131072;
        if (flip) begin
            for (int i = 0; i < 4; i++) b[i] = -b[i];
        end
        lin = mag >= lerp_thr;
        if (!lin) begin
            d = (mag > 32768) ? 32768 : mag;
            s = isqrt64(longint'(ONE_Q30 - d * d) << 30);
            // degenerate angle falls back to the linear blend
            if (s == 0) begin
                lin = 1'b1;
            end else begin
                theta = angle_of(s, d * 32768);
                s2 = sine_of((theta * t) >>> 15);
                s3 = sine_of((theta * (32768 - t)) >>> 15);
                for (int i = 0; i < 4; i++) r[i] = div_nearest(a[i] * s3 + b[i] * s2, s);
            end
        end
        if (lin) begin
            for (int i = 0; i < 4; i++) r[i] = (a[i] * 32768 + t * (b[i] - a[i]) + 16384) >>> 15;
        end
        o.r_x = clip16(r[0]);
        o.r_y = clip16(r[1]);
        o.r_z = clip16(r[2]);
        o.r_w = clip16(r[3]);
        o.used_linear = lin;
        o.flipped = flip;
        return o;
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic qs_in_t make_item(longint ax, longint ay, longint az, longint aw,
                                         longint bx, longint by, longint bz, longint bw,
                                         longint rt);
        qs_in_t x;
        x.a_x = 16'(ax); x.a_y = 16'(ay); x.a_z = 16'(az); x.a_w = 16'(aw);
        x.b_x = 16'(bx); x.b_y = 16'(by); x.b_z = 16'(bz); x.b_w = 16'(bw);
        x.rate = 16'(rt);
        return x;
    endfunction

    function automatic longint rand_s16();
        return longint'($urandom_range(0, 65535)) - 32768;
    endfunction

    // Random quaternion of length near 1.0 (16384)
    task automatic rand_unit(output longint q [4]);
        real v [4];
        real n;
        n = 0.0;
        for (int i = 0; i < 4; i++) begin
            v[i] = real'(rand_s16());
            n += v[i] * v[i];
        end
        if (n == 0.0) begin
            v[3] = 1.0;
            n = 1.0;
        end
        n = $sqrt(n);
        for (int i = 0; i < 4; i++) q[i] = longint'(v[i] * 16384.0 / n);
    endtask

    function automatic longint rand_rate();
        int k;
        k = $urandom_range(0, 15);
        if (k == 0) return 0;
        if (k == 1) return 32768;
        if (k == 2) return $urandom_range(32769, 65535);
        return $urandom_range(0, 32768);
    endfunction

    task automatic rand_item(output qs_in_t x);
        longint a [4];
        longint b [4];
        longint spread;
        int     kind;
        kind = $urandom_range(0, 9);
        if (kind < 2) begin
            // raw bits, mostly far outside unit length
            x = make_item(rand_s16(), rand_s16(), rand_s16(), rand_s16(),
                          rand_s16(), rand_s16(), rand_s16(), rand_s16(),
                          $urandom_range(0, 65535));
        end else begin
            rand_unit(a);
            if (kind < 6) begin
                rand_unit(b);
            end else begin
                // b close to +a or -a to land near the threshold
                spread = 1 << $urandom_range(4, 13);
                for (int i = 0; i < 4; i++) begin
                    b[i] = a[i] + longint'($urandom_range(0, 2 * spread)) - spread;
                    if (kind == 9) b[i] = -b[i];
                end
            end
            x = make_item(a[0], a[1], a[2], a[3], b[0], b[1], b[2], b[3], rand_rate());
        end
    endtask

    // Send one beat; the expectation is taken at acceptance
    task automatic send_quat(input qs_in_t x);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= x;
        do @(posedge aclk); while (!s_ready);
        expected_blends.push_back(predict_blend(x));
    endtask

    task automatic stop_stream();
        s_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_blends.size() != 0) @(posedge aclk);
    endtask

    // Callers stop the stream before this
    task automatic write_threshold(input logic [15:0] v);
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        lerp_thr = v;
    endtask

    // ---------------- tests ----------------

    task automatic test_directed();
        send_quat(make_item(0, 0, 0, 16384, 0, 0, 0, 16384, 16384));
        send_quat(make_item(0, 0, 0, 16384, 16384, 0, 0, 0, 0));
        send_quat(make_item(0, 0, 0, 16384, 16384, 0, 0, 0, 32768));
        send_quat(make_item(0, 0, 0, 16384, 16384, 0, 0, 0, 16384));
        // rate above one
        send_quat(make_item(0, 0, 0, 16384, 16384, 0, 0, 0, 65535));
        send_quat(make_item(0, 0, 11585, 11585, 16384, 0, 0, 0, 40000));
        // negative dot flips b
        send_quat(make_item(0, 0, 0, 16384, 0, 0, 11585, -11585, 8192));
        send_quat(make_item(0, 0, 0, 16384, 0, 0, 0, -16384, 20000));
        // zero dot is not negative
        send_quat(make_item(16384, 0, 0, 0, 0, -16384, 0, 0, 24576));
        // negated minimum
        send_quat(make_item(-32768, -32768, -32768, -32768, -32768, 32767, 32767, 32767, 16384));
        send_quat(make_item(32767, 32767, 32767, 32767, -32768, -32768, -32768, -32768, 100));
        send_quat(make_item(32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768, 32768));
        send_quat(make_item(-32768, 0, 0, 0, -32768, 0, 0, 0, 1));
        send_quat(make_item(0, 0, 0, 0, 0, 0, 0, 0, 12345));
        // dot near 0.8, below the reset threshold of 0.95
        send_quat(make_item(0, 0, 5111, 15565, 0, 0, -5111, 15565, 16384));
        send_quat(make_item(0, 0, 5200, 15537, 0, 0, -5200, 15537, 16384));
        send_quat(make_item(1, -1, 1, -1, -1, 1, -1, 1, 0));
        stop_stream();
    endtask

    // Threshold above 1.0: parallel and opposite pairs reach the degenerate angle
    task automatic test_degenerate_angle();
        write_threshold(16'hffff);
        send_quat(make_item(0, 0, 0, 16384, 0, 0, 0, 16384, 9000));
        send_quat(make_item(16384, 0, 0, 0, -16384, 0, 0, 0, 30000));
        send_quat(make_item(32767, 32767, 0, 0, 32767, 32767, 0, 0, 16384));
        send_quat(make_item(0, 0, 11585, 11585, 11585, 0, 0, 11585, 16384));
        stop_stream();
    endtask

    task automatic test_random_phase(input logic [15:0] thr, input int count, input bit hold);
        qs_in_t x;
        write_threshold(thr);
        for (int n = 0; n < count; n++) begin
            rand_item(x);
            send_quat(x);
            // hold the sender until every result has come back
            if (hold && n == count / 2) begin
                stop_stream();
                wait_drained();
            end
        end
        stop_stream();
    endtask

    // ---------------- result checking ----------------

    always @(posedge aclk) begin
        qs_out_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_blends.size() == 0) begin
                errors++;
                $display("%t: unexpected result beat %h", $realtime, m_data);
            end else begin
                e = expected_blends.pop_front();
                if (m_data.r_x !== e.r_x || m_data.r_y !== e.r_y || m_data.r_z !== e.r_z ||
                    m_data.r_w !== e.r_w || m_data.used_linear !== e.used_linear ||
                    m_data.flipped !== e.flipped) begin
                    errors++;
                    $display("%t: mismatch expected r=(%0d %0d %0d %0d) lin=%b flip=%b",
                             $realtime, e.r_x, e.r_y, e.r_z, e.r_w, e.used_linear, e.flipped);
                    $display("%t:          actual   r=(%0d %0d %0d %0d) lin=%b flip=%b",
                             $realtime, m_data.r_x, m_data.r_y, m_data.r_z, m_data.r_w,
                             m_data.used_linear, m_data.flipped);
                end
            end
        end
    end

    // Stall the result side in random bursts
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (idle_on && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    // Run limit
    initial begin
        #5ms;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        errors    = 0;
        idle_on   = 1'b1;
        lerp_thr  = 31130;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_degenerate_angle();
        test_random_phase(16'd31130, 190, 1'b1);
        test_random_phase(16'd0, 150, 1'b0);
        test_random_phase(16'd32768, 150, 1'b0);
        test_random_phase(16'($urandom_range(20000, 32768)), 200, 1'b0);
        idle_on = 1'b0;
        test_random_phase(16'd31130, 240, 1'b0);

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
